### src/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_PRESS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLICK_GAP    = 2'd3;

    // Configuration reset values in milliseconds.
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd600;
    localparam logic [CFG_W-1:0] HOLD_TIMEOUT_RST = 16'd5600;
    localparam logic [CFG_W-1:0] MIN_PRESS_RST    = 16'd20;
    localparam logic [CFG_W-1:0] CLICK_GAP_RST    = 16'd200;

    // Request kinds and pin levels.
    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_SCAN   = 1'b1;
    localparam logic PIN_PRESSED = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_DOWN    = 3'd1,
        ST_HOLD    = 3'd2,
        ST_UP      = 3'd3,
        ST_CONFIRM = 3'd4,
        ST_JUDGE   = 3'd5,
        ST_ACTION  = 3'd6
    } key_state_t;

    typedef enum logic [1:0] {
        EV_LONG    = 2'd0,
        EV_LONG_UP = 2'd1,
        EV_DOUBLE  = 2'd2,
        EV_SHORT   = 2'd3
    } event_code_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] hold_timeout_ms;
        logic [CFG_W-1:0] min_press_ms;
        logic [CFG_W-1:0] click_gap_ms;
    } kpc_cfg_t;

    typedef struct packed {
        logic        valid;
        event_code_t code;
    } kpc_result_t;

endpackage

### src/kpc_cfg.sv
// ----------------------------------------------------------------------------
// kpc_cfg
// Configuration register file of the key press classifier.
// ----------------------------------------------------------------------------
module kpc_cfg import kpc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output kpc_cfg_t             cfg
);

    kpc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms   <= LONG_PRESS_RST;
            cfg_reg.hold_timeout_ms <= HOLD_TIMEOUT_RST;
            cfg_reg.min_press_ms    <= MIN_PRESS_RST;
            cfg_reg.click_gap_ms    <= CLICK_GAP_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_wdata;
                CFG_IDX_HOLD_TIMEOUT: cfg_reg.hold_timeout_ms <= cfg_wdata;
                CFG_IDX_MIN_PRESS:    cfg_reg.min_press_ms    <= cfg_wdata;
                CFG_IDX_CLICK_GAP:    cfg_reg.click_gap_ms    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/kpc_core.sv
// ----------------------------------------------------------------------------
// kpc_core
// Key state machine: timestamps, flags and the event decision per request.
// ----------------------------------------------------------------------------
module kpc_core import kpc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              kind,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] now_ms,
    input  kpc_cfg_t          cfg,
    output kpc_result_t       result
);

    key_state_t        state_reg, state_next;
    key_state_t        prev_reg, prev_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    logic [TIME_W-1:0] release_time_reg, release_time_next;
    logic              double_reg, double_next;
    logic              long_reg, long_next;
    event_code_t       pending_reg, pending_next;

    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_release;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            prev_reg         <= ST_IDLE;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            double_reg       <= 1'b0;
            long_reg         <= 1'b0;
            pending_reg      <= EV_LONG;
        end else if (advance) begin
            state_reg        <= state_next;
            prev_reg         <= prev_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            double_reg       <= double_next;
            long_reg         <= long_next;
            pending_reg      <= pending_next;
        end
    end

    // Elapsed times wrap modulo 2^32, as the timestamps do.
    assign since_press   = now_ms - press_time_reg;
    assign since_release = now_ms - release_time_reg;

    always_comb begin
        state_next        = state_reg;
        prev_next         = prev_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        double_next       = double_reg;
        long_next         = long_reg;
        pending_next      = pending_reg;
        result.valid      = 1'b0;
        result.code       = pending_reg;

        if (kind == KIND_EDGE) begin
            prev_next  = state_reg;
            state_next = (pin_level == PIN_PRESSED) ? ST_DOWN : ST_UP;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    double_next = 1'b0;
                    long_next   = 1'b0;
                end
                ST_DOWN: begin
                    if (prev_reg == ST_CONFIRM) begin
                        double_next = 1'b1;
                    end
                    press_time_next = now_ms;
                    prev_next       = state_reg;
                    state_next      = ST_HOLD;
                end
                ST_HOLD: begin
                    if (since_press > TIME_W'(cfg.long_press_ms)) begin
                        pending_next = EV_LONG;
                        long_next    = 1'b1;
                        result.valid = 1'b1;
                        result.code  = EV_LONG;
                    end
                    if (since_press > TIME_W'(cfg.hold_timeout_ms)) begin
                        prev_next  = state_reg;
                        state_next = ST_JUDGE;
                    end
                end
                ST_UP: begin
                    prev_next = state_reg;
                    if (prev_reg == ST_IDLE) begin
                        state_next = ST_IDLE;
                    end else begin
                        // The release time is now, so the press length is since_press.
                        release_time_next = now_ms;
                        if (since_press > TIME_W'(cfg.min_press_ms)) begin
                            state_next = ST_CONFIRM;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                ST_CONFIRM: begin
                    if (since_release > TIME_W'(cfg.click_gap_ms)) begin
                        if (long_reg) begin
                            pending_next = EV_LONG_UP;
                        end else if (double_reg) begin
                            pending_next = EV_DOUBLE;
                        end else begin
                            pending_next = EV_SHORT;
                        end
                        prev_next  = state_reg;
                        state_next = ST_JUDGE;
                    end
                end
                ST_JUDGE: begin
                    prev_next  = state_reg;
                    state_next = ST_ACTION;
                end
                ST_ACTION: begin
                    double_next  = 1'b0;
                    long_next    = 1'b0;
                    prev_next    = state_reg;
                    state_next   = ST_IDLE;
                    result.valid = 1'b1;
                    result.code  = pending_reg;
                end
                default: ;
            endcase
        end
    end

endmodule

### src/key_press_classifier_top.sv
// ----------------------------------------------------------------------------
// key_press_classifier_top
// Short, double, long and long-release press classifier for one button.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle on the s_ side, unless a
// result held in the output register stalls it: a pin edge request
// (s_kind = 0) or a periodic scan request (s_kind = 1), each with a
// free-running millisecond timestamp. A request first lands in an input
// register; from there it moves into the key state machine, which updates
// its state in one pass and, when the request yields an event, the event
// code is written to the output register at that same edge. Sustained
// throughput is one request per cycle while m_ready keeps the output
// register drained. Edge requests never produce an event; a scan produces
// at most one. While a result waits in the output register, s_ready stays
// high as long as the input register is empty or its request can move on.
// The user must write the four thresholds through the cfg_ port only while
// no request is in flight; the block itself does not enforce this. Index 0
// is long_press_ms, 1 hold_timeout_ms, 2 min_press_ms and 3 click_gap_ms.
// ----------------------------------------------------------------------------
module key_press_classifier_top import kpc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic                 s_pin_level,
    input  logic [TIME_W-1:0]    s_now_ms,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_event_code,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic              in_valid_reg;
    logic              in_kind_reg;
    logic              in_pin_reg;
    logic [TIME_W-1:0] in_now_reg;

    logic              out_valid_reg;
    event_code_t       out_code_reg;

    logic              advance;
    kpc_cfg_t          cfg;
    kpc_result_t       result;

    // The held request moves into the core when the output register is
    // free or being drained in this same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_pin_reg  <= s_pin_level;
            in_now_reg  <= s_now_ms;
        end
    end

    kpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kpc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .kind      (in_kind_reg),
        .pin_level (in_pin_reg),
        .now_ms    (in_now_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Output register: loaded by an event, cleared when the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && result.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_code_reg <= result.code;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_code = out_code_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key press classifier: directed presses first,
// then randomized button gestures under several threshold settings.
// ----------------------------------------------------------------------------
// Every accepted request is run through a cycle-free copy of the classifier
// kept inside this bench. When that copy says a request yields an event, the
// event code is queued. A separate process pops the queue for each event the
// block hands out and compares the codes. Both handshake sides idle at random,
// and the thresholds are rewritten only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top import kpc_pkg::*; ();

    localparam int  CLK_HALF       = 4;
    localparam int  SETTLE_CYCLES  = 6;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  GESTURE_ITEMS  = 290;
    localparam logic PIN_RELEASED  = ~PIN_PRESSED;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic                 s_pin_level;
    logic [TIME_W-1:0]    s_now_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_event_code;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    // Bench copy of the classifier state and its thresholds.
    key_state_t        key_now;
    key_state_t        key_prev;
    logic [TIME_W-1:0] press_at;
    logic [TIME_W-1:0] release_at;
    bit                double_seen;
    bit                long_seen;
    event_code_t       pending_event;
    logic [CFG_W-1:0]  long_lim;
    logic [CFG_W-1:0]  hold_lim;
    logic [CFG_W-1:0]  min_lim;
    logic [CFG_W-1:0]  gap_lim;

    // Event codes still owed by the block, oldest first.
    event_code_t expected_codes[$];
    event_code_t oldest_code;

    // Millisecond clock that the gesture generator walks forward.
    logic [TIME_W-1:0] clock_ms;

    int unsigned max_send_gap;
    int unsigned max_sink_stall;
    int unsigned requests_sent;
    int unsigned scans_sent;
    int unsigned threshold_sets;
    int unsigned mismatches;
    int unsigned events_seen[4];
    int unsigned quiet_cycles = 0;

    key_press_classifier_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_pin_level  (s_pin_level),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Classifier prediction
    // ------------------------------------------------------------------------

    // Every state change remembers the state it leaves.
    function automatic void step_to(input key_state_t next);
        key_prev = key_now;
        key_now  = next;
    endfunction

    // Applies one request to the bench copy of the classifier. Returns 1 when
    // the request yields an event, with its code in code.
    function automatic bit classify_request(input logic kind, input logic level,
                                            input logic [TIME_W-1:0] now,
                                            output event_code_t code);
        logic [TIME_W-1:0] held;
        bit                fired;
        fired = 1'b0;
        code  = EV_LONG;
        if (kind == KIND_EDGE) begin
            // A pin edge only records where the pin went.
            if (level == PIN_PRESSED) begin
                step_to(ST_DOWN);
            end else begin
                step_to(ST_UP);
            end
        end else begin
            case (key_now)
                ST_IDLE: begin
                    double_seen = 1'b0;
                    long_seen   = 1'b0;
                end
                ST_DOWN: begin
                    // A press that lands while a click is being confirmed
                    // turns the gesture into a double click.
                    if (key_prev == ST_CONFIRM) begin
                        double_seen = 1'b1;
                    end
                    press_at = now;
                    step_to(ST_HOLD);
                end
                ST_HOLD: begin
                    held = now - press_at;
                    if (held > long_lim) begin
                        pending_event = EV_LONG;
                        long_seen     = 1'b1;
                        code          = EV_LONG;
                        fired         = 1'b1;
                    end
                    if (held > hold_lim) begin
                        step_to(ST_JUDGE);
                    end
                end
                ST_UP: begin
                    if (key_prev == ST_IDLE) begin
                        step_to(ST_IDLE);
                    end else begin
                        release_at = now;
                        if (release_at - press_at > min_lim) begin
                            step_to(ST_CONFIRM);
                        end else begin
                            step_to(ST_IDLE);
                        end
                    end
                end
                ST_CONFIRM: begin
                    if (now - release_at > gap_lim) begin
                        if (long_seen) begin
                            pending_event = EV_LONG_UP;
                        end else if (double_seen) begin
                            pending_event = EV_DOUBLE;
                        end else begin
                            pending_event = EV_SHORT;
                        end
                        step_to(ST_JUDGE);
                    end
                end
                ST_JUDGE: begin
                    step_to(ST_ACTION);
                end
                ST_ACTION: begin
                    double_seen = 1'b0;
                    long_seen   = 1'b0;
                    step_to(ST_IDLE);
                    code  = pending_event;
                    fired = 1'b1;
                end
                default: begin
                end
            endcase
        end
        return fired;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Sends one request, starting and ending at a falling edge. A random gap
    // comes first; with no gap, valid simply stays high for the next request.
    task automatic send_request(input logic kind, input logic level,
                                input logic [TIME_W-1:0] now);
        int unsigned gap;
        event_code_t code;
        gap = $urandom_range(0, max_send_gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_pin_level <= level;
        s_now_ms    <= now;
        do @(posedge aclk); while (!s_ready);
        if (classify_request(kind, level, now, code)) begin
            expected_codes.push_back(code);
        end
        requests_sent++;
        if (kind == KIND_SCAN) begin
            scans_sent++;
        end
        @(negedge aclk);
    endtask

    // Scans ignore the pin level, so it is drawn at random.
    task automatic send_scan(input logic [TIME_W-1:0] now);
        logic level;
        level = 1'($urandom_range(0, 1));
        send_request(KIND_SCAN, level, now);
    endtask

    // Stops sending, waits for every owed event, then lets the block settle so
    // that it can finish a request that yields nothing.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (expected_codes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Rewrites all four thresholds while the block is idle. Write enable is
    // held high across the four back-to-back writes.
    task automatic set_thresholds(input logic [CFG_W-1:0] long_ms,
                                  input logic [CFG_W-1:0] hold_ms,
                                  input logic [CFG_W-1:0] min_ms,
                                  input logic [CFG_W-1:0] gap_ms);
        logic [CFG_IDX_W-1:0] reg_index [4];
        logic [CFG_W-1:0]     reg_value [4];
        reg_index = '{CFG_IDX_LONG_PRESS, CFG_IDX_HOLD_TIMEOUT,
                      CFG_IDX_MIN_PRESS, CFG_IDX_CLICK_GAP};
        reg_value = '{long_ms, hold_ms, min_ms, gap_ms};
        drain_and_settle();
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= reg_index[i];
            cfg_wdata <= reg_value[i];
            @(negedge aclk);
        end
        cfg_we   <= 1'b0;
        long_lim = long_ms;
        hold_lim = hold_ms;
        min_lim  = min_ms;
        gap_lim  = gap_ms;
        threshold_sets++;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Gesture generation
    // ------------------------------------------------------------------------

    // One press, or two when a double click is tried, with scans spread over
    // each hold, then the quiet time that lets the click be decided and
    // reported. Hold lengths are drawn around the current thresholds so that
    // bounces, clicks, long presses and timeouts all come up.
    task automatic press_gesture();
        int unsigned       clicks;
        int unsigned       held;
        int unsigned       scans;
        int unsigned       extra;
        logic [TIME_W-1:0] t0;
        clicks = ($urandom_range(0, 3) == 0) ? 2 : 1;
        for (int unsigned c = 0; c < clicks; c++) begin
            case ($urandom_range(0, 3))
                0:       held = $urandom_range(0, min_lim);
                1:       held = $urandom_range(min_lim + 1, long_lim);
                2:       held = $urandom_range(long_lim + 1, hold_lim);
                default: held = $urandom_range(hold_lim + 1, hold_lim + 1000);
            endcase
            t0 = clock_ms;
            send_request(KIND_EDGE, PIN_PRESSED, t0);
            scans = $urandom_range(1, 5);
            for (int unsigned i = 0; i <= scans; i++) begin
                send_scan(t0 + held * i / scans);
            end
            // A few scans at the end of the hold let a timed-out press run
            // on to its report before the key comes up.
            extra = $urandom_range(0, 2);
            clock_ms = t0 + held;
            repeat (extra) send_scan(clock_ms);
            send_request(KIND_EDGE, PIN_RELEASED, clock_ms);
            send_scan(clock_ms);
            if (c + 1 < clicks) begin
                // Second press lands inside the click gap.
                clock_ms = clock_ms + $urandom_range(0, gap_lim);
                if ($urandom_range(0, 1) == 0) begin
                    send_scan(clock_ms);
                end
            end
        end
        send_scan(clock_ms + $urandom_range(0, gap_lim));
        clock_ms = clock_ms + gap_lim + 1 + $urandom_range(0, 50);
        send_scan(clock_ms);
        extra = $urandom_range(2, 4);
        repeat (extra) begin
            clock_ms = clock_ms + $urandom_range(0, 20);
            send_scan(clock_ms);
        end
    endtask

    // Short bursts of arbitrary requests: stray edges, scans in odd states
    // and jumps of the time base, some of them just short of the wrap.
    task automatic inject_noise();
        int unsigned burst;
        logic        kind;
        logic        level;
        burst = $urandom_range(1, 4);
        repeat (burst) begin
            case ($urandom_range(0, 3))
                0:       clock_ms = $urandom();
                1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
                default: clock_ms = clock_ms + $urandom_range(0, 2 * hold_lim + 2);
            endcase
            kind  = 1'($urandom_range(0, 1));
            level = 1'($urandom_range(0, 1));
            send_request(kind, level, clock_ms);
        end
    endtask

    task automatic run_gestures(input int unsigned count);
        int unsigned stop_at;
        stop_at  = requests_sent + count;
        clock_ms = $urandom();
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                inject_noise();
            end else begin
                press_gesture();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed tests, all under the reset thresholds (600, 5600, 20, 200)
    // ------------------------------------------------------------------------

    // A 100 ms click whose timestamps cross the 32-bit wrap.
    task automatic test_short_click_across_wrap();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_FFC0;
        send_request(KIND_EDGE, PIN_PRESSED, t0);
        send_request(KIND_SCAN, PIN_RELEASED, t0);
        send_request(KIND_EDGE, PIN_RELEASED, t0 + 100);
        send_request(KIND_SCAN, PIN_PRESSED, t0 + 100);
        send_request(KIND_SCAN, PIN_PRESSED, t0 + 301);
        send_request(KIND_SCAN, PIN_RELEASED, t0 + 302);
        send_request(KIND_SCAN, PIN_PRESSED, t0 + 303);
    endtask

    // Held past both thresholds: long-held events, then the timeout concludes
    // the press in the same scan that reports it. Covers time stamps 0 and
    // all ones.
    task automatic test_hold_timeout();
        send_request(KIND_EDGE, PIN_PRESSED, 32'd0);
        send_request(KIND_SCAN, PIN_PRESSED, 32'd0);
        send_request(KIND_SCAN, PIN_PRESSED, 32'd601);
        send_request(KIND_SCAN, PIN_PRESSED, 32'd5601);
        send_request(KIND_SCAN, PIN_PRESSED, 32'd5602);
        send_request(KIND_SCAN, PIN_PRESSED, 32'hFFFF_FFFF);
    endtask

    // Long press released normally: reported as a long release.
    task automatic test_long_release();
        send_request(KIND_EDGE, PIN_PRESSED, 32'd5000);
        send_request(KIND_SCAN, PIN_PRESSED, 32'd5000);
        send_request(KIND_SCAN, PIN_PRESSED, 32'd5700);
        send_request(KIND_EDGE, PIN_RELEASED, 32'd5800);
        send_request(KIND_SCAN, PIN_RELEASED, 32'd5800);
        send_request(KIND_SCAN, PIN_RELEASED, 32'd6001);
        send_request(KIND_SCAN, PIN_RELEASED, 32'd6002);
        send_request(KIND_SCAN, PIN_RELEASED, 32'd6003);
    endtask

    // A press held exactly the minimum time is thrown away as bounce.
    task automatic test_bounce_rejected();
        send_request(KIND_EDGE, PIN_PRESSED, 32'd1000);
        send_request(KIND_SCAN, PIN_PRESSED, 32'd1000);
        send_request(KIND_EDGE, PIN_RELEASED, 32'd1020);
        send_request(KIND_SCAN, PIN_RELEASED, 32'd1020);
    endtask

    // A release edge straight out of idle goes back to idle without taking
    // a release time.
    task automatic test_release_without_press();
        send_request(KIND_EDGE, PIN_RELEASED, 32'd2000);
        send_request(KIND_SCAN, PIN_RELEASED, 32'd2000);
    endtask

    // ------------------------------------------------------------------------
    // Random gesture tests, one threshold setting each
    // ------------------------------------------------------------------------

    task automatic test_gestures_default_thresholds();
        max_send_gap   = 12;
        max_sink_stall = 12;
        set_thresholds(LONG_PRESS_RST, HOLD_TIMEOUT_RST, MIN_PRESS_RST, CLICK_GAP_RST);
        run_gestures(GESTURE_ITEMS);
    endtask

    // With every threshold at zero, any held time above zero counts as long and
    // times out at once.
    task automatic test_gestures_zero_thresholds();
        max_send_gap   = 0;
        max_sink_stall = 12;
        set_thresholds('0, '0, '0, '0);
        run_gestures(GESTURE_ITEMS);
    endtask

    task automatic test_gestures_max_thresholds();
        max_send_gap   = 12;
        max_sink_stall = 0;
        set_thresholds('1, '1, '1, '1);
        run_gestures(GESTURE_ITEMS);
    endtask

    // Timeout shorter than the long threshold: a press that times out is
    // concluded with whatever code was left pending. Neither side idles here.
    task automatic test_gestures_timeout_below_long();
        max_send_gap   = 0;
        max_sink_stall = 0;
        set_thresholds(CFG_W'($urandom_range(1000, 5000)), CFG_W'($urandom_range(50, 900)),
                       CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(1, 400)));
        run_gestures(GESTURE_ITEMS);
    endtask

    task automatic test_gestures_mixed_thresholds();
        max_send_gap   = 12;
        max_sink_stall = 12;
        set_thresholds(CFG_W'($urandom_range(0, 1000)), CFG_W'($urandom_range(0, 3000)),
                       CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 1000)));
        run_gestures(GESTURE_ITEMS);
    endtask

    // ------------------------------------------------------------------------
    // Event sink and checker
    // ------------------------------------------------------------------------

    // Ready may drop for a random stall before each event.
    initial begin : event_sink
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, max_sink_stall);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_codes.size() == 0) begin
                $display("%0t: event code %0d arrived with no event owed",
                         $time, m_event_code);
                mismatches++;
            end else begin
                oldest_code = expected_codes.pop_front();
                if (m_event_code !== oldest_code) begin
                    $display("%0t: event code expected %0d (%s), actual %0d",
                             $time, oldest_code, oldest_code.name(), m_event_code);
                    mismatches++;
                end
            end
            if (!$isunknown(m_event_code)) begin
                events_seen[m_event_code]++;
            end
        end
    end

    // Ends the run when neither a request nor an event has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: nothing moved for %0d cycles, %0d events still owed",
                     $time, WATCHDOG_LIMIT, expected_codes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_kind      <= KIND_EDGE;
        s_pin_level <= PIN_RELEASED;
        s_now_ms    <= '0;
        cfg_we      <= 1'b0;
        cfg_addr    <= CFG_IDX_LONG_PRESS;
        cfg_wdata   <= '0;

        // The bench copy starts where the block does after reset.
        key_now        = ST_IDLE;
        key_prev       = ST_IDLE;
        press_at       = '0;
        release_at     = '0;
        double_seen    = 1'b0;
        long_seen      = 1'b0;
        pending_event  = EV_LONG;
        long_lim       = LONG_PRESS_RST;
        hold_lim       = HOLD_TIMEOUT_RST;
        min_lim        = MIN_PRESS_RST;
        gap_lim        = CLICK_GAP_RST;
        max_send_gap   = 12;
        max_sink_stall = 12;
        requests_sent  = 0;
        scans_sent     = 0;
        threshold_sets = 0;
        mismatches     = 0;
        events_seen    = '{0, 0, 0, 0};

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_short_click_across_wrap();
        test_hold_timeout();
        test_long_release();
        test_bounce_rejected();
        test_release_without_press();

        test_gestures_default_thresholds();
        test_gestures_zero_thresholds();
        test_gestures_max_thresholds();
        test_gestures_timeout_below_long();
        test_gestures_mixed_thresholds();

        drain_and_settle();
        $display("Ran %0d requests (%0d of them scans) over %0d threshold settings.",
                 requests_sent, scans_sent, threshold_sets);
        $display("Events checked: %0d long held, %0d long released, %0d double, %0d short.",
                 events_seen[EV_LONG], events_seen[EV_LONG_UP],
                 events_seen[EV_DOUBLE], events_seen[EV_SHORT]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
src/kpc_pkg.sv
src/kpc_cfg.sv
src/kpc_core.sv
src/key_press_classifier_top.sv
verif/tb_top.sv
